FILE: src/halfband_upsample_2x_stereo_top_assert.svh
// Assertion macros for the stereo 2x half-band upsampler.
// Used by the modules that assert; expects clk_i and rst_ni in scope.
`ifndef HALFBAND_UPSAMPLE_2X_STEREO_TOP_ASSERT_SVH
`define HALFBAND_UPSAMPLE_2X_STEREO_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check outside reset.
`define HBU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hbu: assertion failed");
// Check at every edge, reset included.
`define HBU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hbu: assertion failed");
`else
`define HBU_ASSERT(lbl, prop)
`define HBU_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: src/hbu_pkg.sv
// Shared types and constants for the stereo 2x half-band upsampler.
// No dependencies; imported by every module and interface of the block.
package hbu_pkg;

  localparam int SampleW   = 16;
  localparam int Shift     = 4;
  localparam int AccW      = 21;   // holds -p + 9c + 9n - m + 8 for 16-bit samples
  localparam int HistDepth = 3;
  localparam int JobCells  = 6;    // p, c, n, m taps of up to three output steps

  localparam logic [1:0] FillMax  = 2'd3;
  localparam logic [1:0] StepsMax = 2'd3;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [AccW-1:0]    RoundAdd  = AccW'(8);

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } pair_t;

  // Work handed from the history row to the job row on an input transfer.
  typedef struct packed {
    logic [1:0] steps;
    logic       frame_end;
  } job_load_t;

endpackage

FILE: src/hbu_in_if.sv
// Input channel of the upsampler: one stereo pair and an end-of-frame flag.
// Depends on hbu_pkg.
interface hbu_in_if import hbu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_in;
  logic signed [SampleW-1:0] right_in;
  logic                      frame_end;

  modport source (output valid, output left_in, output right_in, output frame_end,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input frame_end,
                  output ready);
endinterface

FILE: src/hbu_out_if.sv
// Output channel of the upsampler: one stereo pair with run and frame flags.
// Depends on hbu_pkg.
interface hbu_out_if import hbu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_out;
  logic signed [SampleW-1:0] right_out;
  logic                      run_end;
  logic                      frame_done;

  modport source (output valid, output left_out, output right_out, output run_end,
                  output frame_done, input ready);
  modport sink   (input valid, input left_out, input right_out, input run_end,
                  input frame_done, output ready);
endinterface

FILE: src/hbu_cell.sv
// One cell of a sample row: holds a stereo pair, loads or takes its neighbor.
// Depends on hbu_pkg.
module hbu_cell import hbu_pkg::*; (
  input  logic  clk_i,
  input  logic  load_i,
  input  logic  shift_i,
  input  pair_t load_pair_i,
  input  pair_t next_pair_i,
  output pair_t pair_o
);

  pair_t pair_q;
  pair_t pair_d;

  always_comb begin
    pair_d = pair_q;
    if (load_i) begin
      pair_d = load_pair_i;
    end else if (shift_i) begin
      pair_d = next_pair_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign pair_o = pair_q;

endmodule

FILE: src/hbu_fir.sv
// Four-tap half-band interpolation (-1, 9, 9, -1) with rounding and saturation.
// Depends on hbu_pkg.
module hbu_fir import hbu_pkg::*; (
  input  pair_t prev_i,
  input  pair_t cur_i,
  input  pair_t next_i,
  input  pair_t next2_i,
  output pair_t interp_o
);

  function automatic logic signed [SampleW-1:0] tap_sum(
    input logic signed [SampleW-1:0] p,
    input logic signed [SampleW-1:0] c,
    input logic signed [SampleW-1:0] n,
    input logic signed [SampleW-1:0] m
  );
    logic signed [AccW-1:0]       pe;
    logic signed [AccW-1:0]       ce;
    logic signed [AccW-1:0]       ne;
    logic signed [AccW-1:0]       me;
    logic signed [AccW-1:0]       acc;
    logic signed [AccW-Shift-1:0] sh;
    logic signed [SampleW-1:0]    res;
    pe  = {{(AccW-SampleW){p[SampleW-1]}}, p};
    ce  = {{(AccW-SampleW){c[SampleW-1]}}, c};
    ne  = {{(AccW-SampleW){n[SampleW-1]}}, n};
    me  = {{(AccW-SampleW){m[SampleW-1]}}, m};
    acc = (ce <<< 3) + ce + (ne <<< 3) + ne - pe - me + RoundAdd;
    // floor shift: drop the low bits of the two's complement sum
    sh  = acc[AccW-1:Shift];
    if (sh[AccW-Shift-1] != sh[SampleW-1]) begin
      res = sh[AccW-Shift-1] ? SampleMin : SampleMax;
    end else begin
      res = sh[SampleW-1:0];
    end
    return res;
  endfunction

  assign interp_o.left  = tap_sum(prev_i.left,  cur_i.left,  next_i.left,  next2_i.left);
  assign interp_o.right = tap_sum(prev_i.right, cur_i.right, next_i.right, next2_i.right);

endmodule

FILE: src/hbu_hist.sv
// Frame history: a row of three cells plus fill count, and the window that
// seeds the job row on each input transfer. Depends on hbu_pkg, hbu_cell.
`include "halfband_upsample_2x_stereo_top_assert.svh"

module hbu_hist import hbu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic      frame_end_i,
  input  pair_t     in_pair_i,
  output job_load_t job_o,
  output pair_t     window_o [JobCells]
);

  pair_t      hist [HistDepth];
  pair_t      seq  [HistDepth+1];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       start;

  // Row of history cells: advance on a mid-frame transfer, clear at frame end.
  for (genvar g = 0; g < HistDepth; g++) begin : g_hist
    pair_t nxt;
    if (g == HistDepth - 1) begin : g_tail
      assign nxt = in_pair_i;
    end else begin : g_mid
      assign nxt = hist[g+1];
    end
    hbu_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (accept_i & frame_end_i),
      .shift_i     (accept_i & ~frame_end_i),
      .load_pair_i ('0),
      .next_pair_i (nxt),
      .pair_o      (hist[g])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      if (frame_end_i) begin
        cnt_d = '0;
      end else if (cnt_q != FillMax) begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Oldest to newest: history then the incoming pair.
  always_comb begin
    for (int i = 0; i < HistDepth; i++) begin
      seq[i] = hist[i];
    end
    seq[HistDepth] = in_pair_i;
  end

  assign start = (cnt_q == FillMax);

  // Job cell k takes the sample at window position start - 1 + k, with the
  // first sample repeated before the frame and the newest repeated after it.
  always_comb begin
    logic [3:0] q;
    logic [1:0] lo;
    logic [1:0] sel;
    lo = 2'd3 - cnt_q;
    for (int k = 0; k < JobCells; k++) begin
      q = 4'd2 - {2'b00, cnt_q} + {3'b000, start} + 4'(k);
      if (q > 4'd3) begin
        sel = 2'd3;
      end else if (q[1:0] < lo) begin
        sel = lo;
      end else begin
        sel = q[1:0];
      end
      window_o[k] = seq[sel];
    end
  end

  always_comb begin
    job_o.frame_end = frame_end_i;
    if (frame_end_i) begin
      case (cnt_q)
        2'd0:    job_o.steps = 2'd1;
        2'd1:    job_o.steps = 2'd2;
        default: job_o.steps = StepsMax;
      endcase
    end else begin
      job_o.steps = (cnt_q >= 2'd2) ? 2'd1 : 2'd0;
    end
  end

  `HBU_ASSERT(a_clear_on_end, accept_i && frame_end_i |=> cnt_q == 2'd0)
  `HBU_ASSERT(a_fill_step, accept_i && !frame_end_i && cnt_q != FillMax |=> cnt_q == $past(cnt_q) + 2'd1)
  `HBU_ASSERT(a_fill_hold, !accept_i |=> cnt_q == $past(cnt_q))

endmodule

FILE: src/halfband_upsample_2x_stereo_top.sv
// Stereo 2x half-band upsampler, top level.
// Depends on hbu_pkg, hbu_in_if, hbu_out_if, hbu_cell, hbu_fir, hbu_hist.
//
// Usage:
//   in_i carries one left/right pair per transfer; frame_end marks the last
//   pair of a frame. out_o carries the result pairs: each original pair as
//   is, then the interpolated pair (-x[n-1] + 9x[n] + 9x[n+1] - x[n+2] + 8)>>4,
//   saturated. run_end flags the last result of an input transfer,
//   frame_done the last result of a frame.
// Output lags input by two pairs; the first two pairs of a frame yield no
// result, and the frame-end pair flushes up to three pairs (six results).
// The copy result of an input transfer passes through the job row and the
// output register before it is valid on out_o; its interpolated result follows.
// Throughput: one result per cycle through the single output register while
// the receiver takes each result.
// A row of six job cells holds the filter taps and advances one sample after
// each interpolated result; the next input transfer can be taken as early as
// the cycle in which the current job's last result enters the output register.
// Reset clears the fill count, the step and phase state and the output valid.
// While the receiver stalls, the output register holds; the job row and in_i
// are stalled as long as the current job still has results to hand over.
`include "halfband_upsample_2x_stereo_top_assert.svh"

module halfband_upsample_2x_stereo_top import hbu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  hbu_in_if.sink           in_i,
  hbu_out_if.source        out_o
);

  pair_t     in_pair;
  pair_t     window [JobCells];
  pair_t     job    [JobCells];
  pair_t     interp;
  job_load_t job_load;

  logic       in_fire;
  logic       out_free;
  logic       emit;
  logic       final_emit;

  logic [1:0] steps_q, steps_d;
  logic       phase_q, phase_d;     // 0: copy result next, 1: interpolated result next
  logic       last_q,  last_d;
  logic       out_valid_q, out_valid_d;
  pair_t      out_pair_q, out_pair_d;
  logic       run_end_q, run_end_d;
  logic       frame_done_q, frame_done_d;

  assign in_pair.left  = in_i.left_in;
  assign in_pair.right = in_i.right_in;

  // Output register frees up when empty or when its content transfers.
  assign out_free   = ~out_valid_q | out_o.ready;
  assign emit       = (steps_q != 2'd0) & out_free;
  assign final_emit = emit & phase_q & (steps_q == 2'd1);

  // Take a new pair when no job is pending or while the last result of the current job moves out.
  assign in_i.ready = (steps_q == 2'd0) | final_emit;
  assign in_fire    = in_i.valid & in_i.ready;

  hbu_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .frame_end_i (in_i.frame_end),
    .in_pair_i   (in_pair),
    .job_o       (job_load),
    .window_o    (window)
  );

  // Job row: load the window on a transfer, advance one sample per step.
  for (genvar g = 0; g < JobCells; g++) begin : g_job
    pair_t nxt;
    if (g == JobCells - 1) begin : g_tail
      assign nxt = job[g];
    end else begin : g_mid
      assign nxt = job[g+1];
    end
    hbu_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (in_fire),
      .shift_i     (emit & phase_q),
      .load_pair_i (window[g]),
      .next_pair_i (nxt),
      .pair_o      (job[g])
    );
  end

  hbu_fir u_fir (
    .prev_i   (job[0]),
    .cur_i    (job[1]),
    .next_i   (job[2]),
    .next2_i  (job[3]),
    .interp_o (interp)
  );

  // Sequencer: copy then interpolate for each step of the job.
  always_comb begin
    steps_d = steps_q;
    phase_d = phase_q;
    last_d  = last_q;
    if (emit) begin
      if (phase_q) begin
        steps_d = steps_q - 2'd1;
        phase_d = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end
    if (in_fire) begin
      steps_d = job_load.steps;
      phase_d = 1'b0;
      last_d  = job_load.frame_end;
    end
  end

  // Output register: fill on a step, drop when the receiver takes it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_pair_d   = out_pair_q;
    run_end_d    = run_end_q;
    frame_done_d = frame_done_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (phase_q) begin
        out_pair_d   = interp;
        run_end_d    = (steps_q == 2'd1);
        frame_done_d = last_q & (steps_q == 2'd1);
      end else begin
        out_pair_d   = job[1];
        run_end_d    = 1'b0;
        frame_done_d = 1'b0;
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      phase_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      steps_q     <= steps_d;
      phase_q     <= phase_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pair_q   <= out_pair_d;
    run_end_q    <= run_end_d;
    frame_done_q <= frame_done_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.left_out   = out_pair_q.left;
  assign out_o.right_out  = out_pair_q.right;
  assign out_o.run_end    = run_end_q;
  assign out_o.frame_done = frame_done_q;

  `HBU_ASSERT_ALWAYS(a_done_ends_run, out_valid_q && frame_done_q |-> run_end_q)
  `HBU_ASSERT(a_run_open, out_valid_q && !run_end_q |-> steps_q != 2'd0)
  `HBU_ASSERT(a_load_fresh, in_fire |=> !phase_q)

endmodule
